// ----- src/sdst_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable descending sorted table package
// Shared constants, entry layout and the transaction types that pass between
// the top level and the table core.
// ----------------------------------------------------------------------------
package sdst_pkg;

    localparam int MAX_ROADS   = 4096;
    localparam int TABLE_DEPTH = 2 * MAX_ROADS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int HELD_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ROAD_CNT_W  = $clog2(MAX_ROADS + 1);

    localparam int FUNC_W      = 2;
    localparam int COUNT_W     = 32;
    localparam int RANK_W      = 13;
    localparam int ROAD_ID_W   = 12;
    localparam int LEN_W       = 14;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_START,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ROAD_ID_W-1:0] road;
        logic                 dir;
        logic [COUNT_W-1:0]   count;
    } entry_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COUNT_W-1:0] count_forward;
        logic [COUNT_W-1:0] count_backward;
        logic [RANK_W-1:0]  rank;
    } cmd_t;

    typedef struct packed {
        logic                 entry_valid;
        logic [ROAD_ID_W-1:0] road_id;
        logic                 direction;
        logic [COUNT_W-1:0]   count;
        logic [LEN_W-1:0]     list_length;
        logic                 overflow;
    } res_t;

endpackage

// ----- src/stable_descending_sorted_table_top.sv -----
// ----------------------------------------------------------------------------
// Stable descending sorted table, top level
// Keeps (road, direction, count) entries sorted by count, largest first.
// ----------------------------------------------------------------------------
// A load inserts each of its entries by walking the table one entry per
// cycle through the single table memory port pair.
// One transaction is processed at a time; the next is accepted as soon as
// the result is in the output register. Reset empties the table at once.
// ----------------------------------------------------------------------------
module stable_descending_sorted_table_top
    import sdst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [COUNT_W-1:0]   count_forward,
    input  logic [COUNT_W-1:0]   count_backward,
    input  logic [RANK_W-1:0]    rank,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 entry_valid,
    output logic [ROAD_ID_W-1:0] road_id,
    output logic                 direction,
    output logic [COUNT_W-1:0]   count,
    output logic [LEN_W-1:0]     list_length,
    output logic                 overflow
);

    // The incoming transaction is bundled for the core, which takes it only
    // while it is idle.
    cmd_t cmd;
    res_t core_res;
    logic core_res_valid;
    logic core_res_ready;

    // Output register: it frees the core as soon as a result is produced, so
    // a new transaction can be accepted while the previous result waits.
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    always_comb
    begin
        cmd.func           = func;
        cmd.count_forward  = count_forward;
        cmd.count_backward = count_backward;
        cmd.rank           = rank;
    end

    sdst_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (in_valid),
        .cmd_ready (in_ready),
        .cmd       (cmd),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    // The register can load when it is empty or its result is taken now.
    assign core_res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (core_res_ready)
        begin
            out_valid_next = core_res_valid;
            if (core_res_valid)
            begin
                out_res_next = core_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign entry_valid = out_res_reg.entry_valid;
    assign road_id     = out_res_reg.road_id;
    assign direction   = out_res_reg.direction;
    assign count       = out_res_reg.count;
    assign list_length = out_res_reg.list_length;
    assign overflow    = out_res_reg.overflow;

endmodule

// ----- src/sdst_core.sv -----
// ----------------------------------------------------------------------------
// Sorted table core
// Holds the sorted entries in one synchronous memory and runs the insertion,
// read and clear sequences on it.
// ----------------------------------------------------------------------------
module sdst_core
    import sdst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    state_t                state_reg, state_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [ROAD_CNT_W-1:0] roads_reg, roads_next;
    logic                  ovf_reg, ovf_next;
    logic [HELD_W-1:0]     pos_reg, pos_next;
    entry_t                new_reg, new_next;
    logic                  second_reg, second_next;
    logic [COUNT_W-1:0]    bwd_reg, bwd_next;
    logic                  hit_reg, hit_next;
    entry_t                rd_reg, rd_next;

    logic [HELD_W-1:0] pos_m1;
    logic [HELD_W-1:0] pos_m2;
    logic [HELD_W-1:0] held_m1;
    logic              ins_done;

    assign pos_m1  = pos_reg - HELD_W'(1);
    assign pos_m2  = pos_reg - HELD_W'(2);
    assign held_m1 = held_reg - HELD_W'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            held_reg   <= '0;
            roads_reg  <= '0;
            ovf_reg    <= 1'b0;
            second_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            roads_reg  <= roads_next;
            ovf_reg    <= ovf_next;
            second_reg <= second_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        new_reg <= new_next;
        bwd_reg <= bwd_next;
        rd_reg  <= rd_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        roads_next  = roads_reg;
        ovf_next    = ovf_reg;
        pos_next    = pos_reg;
        new_next    = new_reg;
        second_next = second_reg;
        bwd_next    = bwd_reg;
        hit_next    = hit_reg;
        rd_next     = rd_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg[ADDR_W-1:0];
        mem_wdata   = new_reg;
        mem_raddr   = '0;
        ins_done    = 1'b0;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                mem_raddr = ADDR_W'(cmd.rank);
                if (cmd_valid)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_RESP;
                    case (cmd.func)
                        FUNC_LOAD:
                        begin
                            if (roads_reg >= ROAD_CNT_W'(MAX_ROADS))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                roads_next   = roads_reg + ROAD_CNT_W'(1);
                                new_next.road = ROAD_ID_W'(roads_reg);
                                bwd_next     = cmd.count_backward;
                                if (cmd.count_forward != '0)
                                begin
                                    new_next.dir   = 1'b0;
                                    new_next.count = cmd.count_forward;
                                    second_next    = (cmd.count_backward != '0);
                                    state_next     = ST_INS_START;
                                end
                                else if (cmd.count_backward != '0)
                                begin
                                    new_next.dir   = 1'b1;
                                    new_next.count = cmd.count_backward;
                                    second_next    = 1'b0;
                                    state_next     = ST_INS_START;
                                end
                            end
                        end
                        FUNC_READ:
                        begin
                            hit_next   = ((HELD_W + 1)'(cmd.rank) < (HELD_W + 1)'(held_reg));
                            state_next = ST_READ;
                        end
                        FUNC_CLEAR:
                        begin
                            held_next  = '0;
                            roads_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_INS_START:
            begin
                if (held_reg >= HELD_W'(TABLE_DEPTH))
                begin
                    ins_done = 1'b1;
                end
                else if (held_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    pos_next   = held_reg;
                    mem_raddr  = held_m1[ADDR_W-1:0];
                    state_next = ST_INS_SHIFT;
                end
            end
            ST_INS_SHIFT:
            begin
                // rdata_reg holds the entry just above the slot at pos_reg.
                mem_we = 1'b1;
                if (rdata_reg.count >= new_reg.count)
                begin
                    mem_wdata = new_reg;
                    held_next = held_reg + HELD_W'(1);
                    ins_done  = 1'b1;
                end
                else
                begin
                    mem_wdata = rdata_reg;
                    pos_next  = pos_m1;
                    if (pos_m1 == '0)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        mem_raddr = pos_m2[ADDR_W-1:0];
                    end
                end
            end
            ST_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_wdata = new_reg;
                held_next = held_reg + HELD_W'(1);
                ins_done  = 1'b1;
            end
            ST_READ:
            begin
                rd_next    = rdata_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ins_done)
        begin
            if (second_reg)
            begin
                second_next    = 1'b0;
                new_next.dir   = 1'b1;
                new_next.count = bwd_reg;
                state_next     = ST_INS_START;
            end
            else
            begin
                state_next = ST_RESP;
            end
        end
    end

    always_comb
    begin
        res.entry_valid = hit_reg;
        res.road_id     = hit_reg ? rd_reg.road  : '0;
        res.direction   = hit_reg ? rd_reg.dir   : 1'b0;
        res.count       = hit_reg ? rd_reg.count : '0;
        res.list_length = LEN_W'(held_reg);
        res.overflow    = ovf_reg;
    end

endmodule

// ----- dv/stable_descending_sorted_table_top_test.sv -----
// ----------------------------------------------------------------------------
// Stable descending sorted table, block-level test
// Drives load, read, clear and unused-code transactions into the table
// through a queue-fed driver and checks every result against a predictor
// kept inside this module. The run passes through three idling regimes
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module stable_descending_sorted_table_top_test
    import sdst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth function code has no meaning in the block. It must be
    // ignored apart from reporting the status.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Cycles with no transaction on either side before the run is abandoned.
    // The slowest correct stretch is the receiver hold-off below plus one
    // load into a table of a few dozen entries, well under this figure.
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_TRIGGER = 25;
    localparam int SETTLE_WAIT  = 20;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func           = '0;
    logic [COUNT_W-1:0]   count_forward  = '0;
    logic [COUNT_W-1:0]   count_backward = '0;
    logic [RANK_W-1:0]    rank           = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic                 entry_valid;
    logic [ROAD_ID_W-1:0] road_id;
    logic                 direction;
    logic [COUNT_W-1:0]   count;
    logic [LEN_W-1:0]     list_length;
    logic                 overflow;

    stable_descending_sorted_table_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .count_forward  (count_forward),
        .count_backward (count_backward),
        .rank           (rank),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entry_valid    (entry_valid),
        .road_id        (road_id),
        .direction      (direction),
        .count          (count),
        .list_length    (list_length),
        .overflow       (overflow)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state. The ranked list mirrors the table held in the block;
    // only ranks below the held count are ever looked at.
    // ------------------------------------------------------------------------
    entry_t ranked_list [TABLE_DEPTH];
    int     held_entries;
    int     roads_seen;
    logic   capacity_flag;

    // Tallies for the closing summary.
    int n_loads, n_reads, n_read_hits, n_clears, n_unused;
    int peak_held;
    bit capacity_hit;

    // Transactions waiting to be offered, and results the block still owes.
    cmd_t pending_commands [$];
    res_t awaited_results  [$];
    cmd_t next_cmd;

    int send_idle_pct;
    int recv_idle_pct;
    int results_checked;
    int mismatch_count;
    int quiet_cycles;
    int hold_left;
    bit hold_started;
    bit in_taken;

    // Places one entry after every entry whose count is greater than or
    // equal to it, which keeps equal counts in arrival order.
    function automatic void insert_ranked(logic [ROAD_ID_W-1:0] road, logic dir,
                                          logic [COUNT_W-1:0] total);
        int pos;
        int k;
        if (held_entries < TABLE_DEPTH)
        begin
            pos = 0;
            while (pos < held_entries && ranked_list[pos].count >= total)
                pos++;
            for (k = held_entries; k > pos; k--)
                ranked_list[k] = ranked_list[k - 1];
            ranked_list[pos].road  = road;
            ranked_list[pos].dir   = dir;
            ranked_list[pos].count = total;
            held_entries++;
            if (held_entries > peak_held)
                peak_held = held_entries;
        end
    endfunction

    // Applies one accepted transaction to the predictor state and returns
    // the result the block must give for it.
    function automatic res_t apply_command(cmd_t c);
        res_t r;
        r = '0;
        case (c.func)
            FUNC_LOAD:
            begin
                n_loads++;
                if (roads_seen >= MAX_ROADS)
                begin
                    // Past capacity the load is dropped and the flag sticks.
                    capacity_flag = 1'b1;
                    capacity_hit  = 1'b1;
                end
                else
                begin
                    // A zero total means that direction is absent, but the
                    // road still takes up an index.
                    if (c.count_forward != '0)
                        insert_ranked(roads_seen[ROAD_ID_W-1:0], 1'b0, c.count_forward);
                    if (c.count_backward != '0)
                        insert_ranked(roads_seen[ROAD_ID_W-1:0], 1'b1, c.count_backward);
                    roads_seen++;
                end
            end
            FUNC_READ:
            begin
                n_reads++;
                if (int'(c.rank) < held_entries)
                begin
                    n_read_hits++;
                    r.entry_valid = 1'b1;
                    r.road_id     = ranked_list[c.rank].road;
                    r.direction   = ranked_list[c.rank].dir;
                    r.count       = ranked_list[c.rank].count;
                end
            end
            FUNC_CLEAR:
            begin
                n_clears++;
                held_entries  = 0;
                roads_seen    = 0;
                capacity_flag = 1'b0;
            end
            default:
            begin
                n_unused++;
            end
        endcase
        r.list_length = LEN_W'(held_entries);
        r.overflow    = capacity_flag;
        return r;
    endfunction

    task automatic check_field(string name, logic [COUNT_W-1:0] want,
                               logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_command(logic [FUNC_W-1:0] f, logic [COUNT_W-1:0] fwd,
                                logic [COUNT_W-1:0] bwd, logic [RANK_W-1:0] rk);
        cmd_t c;
        c.func           = f;
        c.count_forward  = fwd;
        c.count_backward = bwd;
        c.rank           = rk;
        pending_commands.push_back(c);
    endtask

    // Totals mix small values, so that ties are common, with zero (absent),
    // the saturated maximum and fully random values.
    function automatic logic [COUNT_W-1:0] draw_total();
        logic [COUNT_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = $urandom_range(1, 6);
            2:       v = '1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Most reads land inside a table of a few dozen entries; some go anywhere.
    function automatic logic [RANK_W-1:0] draw_rank();
        logic [RANK_W-1:0] v;
        if ($urandom_range(0, 7) == 0)
            v = RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
        else
            v = RANK_W'($urandom_range(0, 47));
        return v;
    endfunction

    task automatic queue_random_traffic(int n);
        int i;
        int pick;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 52)
                push_command(FUNC_LOAD, draw_total(), draw_total(), RANK_W'($urandom));
            else if (pick < 92)
                push_command(FUNC_READ, $urandom, $urandom, draw_rank());
            else if (pick < 96)
                push_command(FUNC_CLEAR, $urandom, $urandom, RANK_W'($urandom));
            else
                push_command(FUNC_UNUSED, $urandom, $urandom, RANK_W'($urandom));
        end
    endtask

    // Returns once every queued transaction has been taken and answered. The
    // short delay after the edge lets the monitor and the driver settle first.
    task automatic wait_drained();
        while (pending_commands.size() != 0 || in_valid || awaited_results.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Payloads change on the falling edge only. A transaction that
    // has been offered stays on the ports until the rising edge at which it
    // is accepted; only then is the next one taken from the queue, or the
    // sender idles.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_cmd = pending_commands.pop_front();
                in_valid       <= 1'b1;
                func           <= next_cmd.func;
                count_forward  <= next_cmd.count_forward;
                count_backward <= next_cmd.count_backward;
                rank           <= next_cmd.rank;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random, and once, after a number of results have
    // been checked, it holds off for a long stretch. The block works on one
    // transaction at a time, so during the hold-off its input stalls while
    // the driver keeps offering.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (!hold_started && results_checked >= HOLD_TRIGGER)
            begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. On each rising edge an accepted input transaction is run
    // through the predictor, and an accepted result is compared, field by
    // field, with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cmd_t seen_cmd;
        res_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                seen_cmd.func           = func;
                seen_cmd.count_forward  = count_forward;
                seen_cmd.count_backward = count_backward;
                seen_cmd.rank           = rank;
                awaited_results.push_back(apply_command(seen_cmd));
            end
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction arrived with no expectation waiting");
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("entry_valid", COUNT_W'(want.entry_valid),
                                COUNT_W'(entry_valid));
                    check_field("road_id", COUNT_W'(want.road_id), COUNT_W'(road_id));
                    check_field("direction", COUNT_W'(want.direction),
                                COUNT_W'(direction));
                    check_field("count", want.count, count);
                    check_field("list_length", COUNT_W'(want.list_length),
                                COUNT_W'(list_length));
                    check_field("overflow", COUNT_W'(want.overflow), COUNT_W'(overflow));
                end
            end
        end
    end

    // Watchdog: abandons the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int i;

        held_entries  = 0;
        roads_seen    = 0;
        capacity_flag = 1'b0;

        // First regime: the sender idles now and then, the receiver often.
        send_idle_pct = 10;
        recv_idle_pct = 62;

        // Directed opening. Road 0 carries the largest and smallest totals.
        push_command(FUNC_READ, '0, '0, '0);          // read of an empty table
        push_command(FUNC_LOAD, '1, 32'd1, '0);
        // Equal totals within one road: the forward direction ranks first.
        push_command(FUNC_LOAD, 32'd5, 32'd5, '0);
        // An equal total from a later road ranks behind; the zero backward
        // total is absent.
        push_command(FUNC_LOAD, 32'd5, '0, '0);
        // Both totals zero: nothing is inserted but a road index is used.
        push_command(FUNC_LOAD, '0, '0, '0);
        // A tie with the largest total from a later road, backward only.
        push_command(FUNC_LOAD, '0, '1, '0);
        push_command(FUNC_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, '0);
        // Walk every rank plus one past the end of the list.
        for (i = 0; i <= 8; i++)
            push_command(FUNC_READ, '0, '0, RANK_W'(i));
        push_command(FUNC_READ, '0, '0, '1);          // highest rank, a miss
        push_command(FUNC_UNUSED, '1, '1, '1);        // ignored, status only
        push_command(FUNC_CLEAR, '0, '0, '0);
        push_command(FUNC_READ, '0, '0, '0);

        queue_random_traffic(30);

        // Reset is released on a falling edge, so the driver sees it still low
        // at that edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_drained();

        // Second regime: the roles are swapped.
        send_idle_pct = 62;
        recv_idle_pct = 10;
        push_command(FUNC_CLEAR, '0, '0, '0);
        queue_random_traffic(25);
        wait_drained();

        // Third regime: back-to-back transactions with no idling at all.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_traffic(25);
        push_command(FUNC_CLEAR, '0, '0, '0);
        push_command(FUNC_LOAD, 32'd3, '0, '0);
        push_command(FUNC_READ, '0, '0, '0);
        wait_drained();

        // Let any late, unexpected result show itself before the verdict.
        repeat (SETTLE_WAIT) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_results.size());
            mismatch_count++;
        end

        $display("Covered %0d loads, %0d reads (%0d hits), %0d clears, %0d unused codes.",
                 n_loads, n_reads, n_read_hits, n_clears, n_unused);
        $display("Largest table held %0d entries; road capacity overflow %s.",
                 peak_held, capacity_hit ? "was exercised" : "was not exercised");
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
